>>> rtl/sqcs_pkg.sv
// shared constants, types and functions of the sequential channel selector
`default_nettype none

package sqcs_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned CountW      = 5;
  localparam int unsigned StepW       = 4;
  localparam int unsigned MvW         = 15;
  localparam int unsigned ProdW       = 19;
  localparam int unsigned OffW        = 6;
  localparam int unsigned ActW        = 7;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 32;
  localparam int unsigned LfsrW       = 32;

  localparam int signed   TrigHighMv  = 1000;
  localparam int unsigned CvFullMv    = 10000;
  // ceil(2^32 / 10000), exact floor quotient for dividends below 2^19
  localparam int unsigned RecipK      = 429497;
  localparam int unsigned RecipShift  = 32;

  localparam logic [LfsrW-1:0] LfsrMask = 32'h8020_0003;

  typedef enum logic [2:0] {
    RegCvEn   = 3'd0,
    RegUpEn   = 3'd1,
    RegDownEn = 3'd2,
    RegRndEn  = 3'd3,
    RegRstEn  = 3'd4,
    RegSeed   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic             cv_en;
    logic             up_en;
    logic             down_en;
    logic             rnd_en;
    logic             rst_en;
    logic             seed_ld;
    logic [LfsrW-1:0] seed;
  } cfg_t;

  // threshold flags of one trigger input
  typedef struct packed {
    logic hi;
    logic lo;
  } trig_t;

  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] cur);
    logic [LfsrW-1:0] sh;
    sh = cur >> 1;
    return cur[0] ? (sh ^ LfsrMask) : sh;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sqcs_schmitt.sv
// schmitt trigger with latch and rising edge detect for one trigger input
`default_nettype none

module sqcs_schmitt (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          en_i,
  input  wire sqcs_pkg::trig_t lvl_i,
  output logic               rise_o
);
  import sqcs_pkg::*;

  logic latch_q, latch_d;

  always_comb begin
    latch_d = latch_q;
    if (adv_i && en_i) begin
      if (latch_q) begin
        if (lvl_i.lo) begin
          latch_d = 1'b0;
        end
      end else if (lvl_i.hi) begin
        latch_d = 1'b1;
      end
    end
  end

  assign rise_o = en_i && !latch_q && lvl_i.hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
    end else begin
      latch_q <= latch_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sqcs_offset.sv
// floor division of the cv product by the full scale voltage
`default_nettype none

module sqcs_offset (
  input  wire logic signed [sqcs_pkg::ProdW-1:0] prod_i,
  output logic signed [sqcs_pkg::OffW-1:0]       off_o
);
  import sqcs_pkg::*;

  logic             neg;
  logic [ProdW-1:0] mag;
  logic [ProdW:0]   num;
  logic [39:0]      scaled;
  logic [4:0]       quo;

  always_comb begin
    neg = prod_i[ProdW-1];
    mag = neg ? (~prod_i + ProdW'(1)) : prod_i;
    // negative side rounds toward minus infinity: ceil of the magnitude
    num = {1'b0, mag} + (neg ? (ProdW+1)'(CvFullMv - 1) : '0);
    scaled = 40'(num) * 40'(RecipK);
    quo = scaled[RecipShift+4:RecipShift];
    off_o = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

endmodule

`default_nettype wire

>>> rtl/sqcs_regs.sv
// apb configuration registers
`default_nettype none

module sqcs_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sqcs_pkg::AddrW-1:0]  paddr,
  input  wire logic [sqcs_pkg::DataW-1:0]  pwdata,
  output logic [sqcs_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  output sqcs_pkg::cfg_t                   cfg_o
);
  import sqcs_pkg::*;

  logic             cv_en_q, up_en_q, down_en_q, rnd_en_q, rst_en_q;
  logic [LfsrW-1:0] seed_q;
  logic             wr;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_en_q   <= 1'b0;
      up_en_q   <= 1'b0;
      down_en_q <= 1'b0;
      rnd_en_q  <= 1'b0;
      rst_en_q  <= 1'b0;
      seed_q    <= LfsrW'(1);
    end else if (wr) begin
      unique case (idx)
        RegCvEn:   cv_en_q   <= pwdata[0];
        RegUpEn:   up_en_q   <= pwdata[0];
        RegDownEn: down_en_q <= pwdata[0];
        RegRndEn:  rnd_en_q  <= pwdata[0];
        RegRstEn:  rst_en_q  <= pwdata[0];
        RegSeed:   seed_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCvEn:   prdata = DataW'(cv_en_q);
      RegUpEn:   prdata = DataW'(up_en_q);
      RegDownEn: prdata = DataW'(down_en_q);
      RegRndEn:  prdata = DataW'(rnd_en_q);
      RegRstEn:  prdata = DataW'(rst_en_q);
      RegSeed:   prdata = seed_q;
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.cv_en   = cv_en_q;
    cfg_o.up_en   = up_en_q;
    cfg_o.down_en = down_en_q;
    cfg_o.rnd_en  = rnd_en_q;
    cfg_o.rst_en  = rst_en_q;
    cfg_o.seed_ld = wr && (idx == RegSeed);
    cfg_o.seed    = pwdata;
  end

endmodule

`default_nettype wire

>>> rtl/sequential_channel_selector_core.sv
// top level: input register, step update and cv offset, result register
// throughput: one transfer per cycle unless out_ready_i stalls the result register;
// input register and result register move together
// step and trigger latches change as an item passes; lfsr on a random step or seed write
// reset: asynchronous, active low; step 0, latches low, lfsr 1, all enables 0, seed 1
// both stages empty after reset, configuration writes taken at any time
`default_nettype none

module sequential_channel_selector_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [sqcs_pkg::CountW-1:0]        channel_count_i,
  input  wire logic signed [sqcs_pkg::MvW-1:0]    cv_millivolts_i,
  input  wire logic signed [sqcs_pkg::MvW-1:0]    up_millivolts_i,
  input  wire logic signed [sqcs_pkg::MvW-1:0]    down_millivolts_i,
  input  wire logic signed [sqcs_pkg::MvW-1:0]    random_millivolts_i,
  input  wire logic signed [sqcs_pkg::MvW-1:0]    reset_millivolts_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [sqcs_pkg::StepW-1:0]              active_channel_o,
  output logic                                    active_valid_o,
  output logic [sqcs_pkg::StepW-1:0]              step_position_o,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sqcs_pkg::AddrW-1:0]         paddr,
  input  wire logic [sqcs_pkg::DataW-1:0]         pwdata,
  output logic [sqcs_pkg::DataW-1:0]              prdata,
  output logic                                    pready
);
  import sqcs_pkg::*;

  cfg_t cfg;

  sqcs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------
  // handshake: the input stage advances whenever the result register is
  // free or being emptied in the same cycle
  // ---------------------------------------------------------------------
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic in_xfer, adv;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // ingress: saturate the count, form the cv product, reduce each trigger
  // voltage to its two schmitt thresholds
  // ---------------------------------------------------------------------
  logic [CountW-1:0]       count_sat;
  logic signed [ProdW-1:0] prod_in;
  logic signed [MvW+CountW:0] prod_full;

  assign count_sat = (channel_count_i > CountW'(MaxChannels)) ? CountW'(MaxChannels)
                                                              : channel_count_i;
  assign prod_full = cv_millivolts_i * $signed({1'b0, count_sat});
  assign prod_in   = prod_full[ProdW-1:0];

  function automatic trig_t thresholds(input logic signed [MvW-1:0] mv);
    trig_t t;
    t.hi = (mv >= MvW'(TrigHighMv));
    t.lo = (mv <= $signed(MvW'(0)));
    return t;
  endfunction

  logic [CountW-1:0]       count_q;
  logic signed [ProdW-1:0] prod_q;
  trig_t                   up_q, down_q, rnd_q, rst_q;

  // payload of the input stage, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      count_q <= count_sat;
      prod_q  <= prod_in;
      up_q    <= thresholds(up_millivolts_i);
      down_q  <= thresholds(down_millivolts_i);
      rnd_q   <= thresholds(random_millivolts_i);
      rst_q   <= thresholds(reset_millivolts_i);
    end
  end

  // ---------------------------------------------------------------------
  // trigger edges, evaluated in order reset, up, down, random
  // ---------------------------------------------------------------------
  logic rst_rise, up_rise, down_rise, rnd_rise;

  sqcs_schmitt u_trig_rst (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
    .en_i  (cfg.rst_en), .lvl_i (rst_q), .rise_o (rst_rise)
  );
  sqcs_schmitt u_trig_up (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
    .en_i  (cfg.up_en), .lvl_i (up_q), .rise_o (up_rise)
  );
  sqcs_schmitt u_trig_down (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
    .en_i  (cfg.down_en), .lvl_i (down_q), .rise_o (down_rise)
  );
  sqcs_schmitt u_trig_rnd (
    .clk_i (clk_i), .rst_ni (rst_ni), .adv_i (adv),
    .en_i  (cfg.rnd_en), .lvl_i (rnd_q), .rise_o (rnd_rise)
  );

  // ---------------------------------------------------------------------
  // step update
  // ---------------------------------------------------------------------
  logic [StepW-1:0]        step_q, step_d;
  logic [LfsrW-1:0]        lfsr_q, lfsr_d, lfsr_adv;
  logic [StepW-1:0]        step_a, step_b, step_c;
  logic [StepW:0]          step_inc;
  logic [LfsrW+CountW-1:0] rnd_prod;

  always_comb begin
    step_a = rst_rise ? '0 : step_q;

    // up wraps to zero at the count
    step_inc = {1'b0, step_a} + (StepW+1)'(1);
    step_b   = step_a;
    if (up_rise) begin
      step_b = (step_inc >= (StepW+1)'(count_q)) ? '0 : step_inc[StepW-1:0];
    end

    // down wraps to the last channel below zero
    step_c = step_b;
    if (down_rise) begin
      priority if (count_q == '0) begin
        step_c = '0;
      end else if (step_b == '0) begin
        step_c = StepW'(count_q - CountW'(1));
      end else begin
        step_c = step_b - StepW'(1);
      end
    end

    // random step: advanced lfsr scaled by the count, top bits kept
    lfsr_adv = lfsr_next(lfsr_q);
    rnd_prod = (LfsrW+CountW)'(lfsr_adv) * (LfsrW+CountW)'(count_q);
    step_d   = rnd_rise ? rnd_prod[LfsrW+StepW-1:LfsrW] : step_c;

    // a seed write reloads the generator, a zero seed becomes one
    lfsr_d = lfsr_q;
    if (cfg.seed_ld) begin
      lfsr_d = (cfg.seed == '0) ? LfsrW'(1) : cfg.seed;
    end else if (adv && rnd_rise) begin
      lfsr_d = lfsr_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      lfsr_q <= LfsrW'(1);
    end else begin
      if (adv) begin
        step_q <= step_d;
      end
      lfsr_q <= lfsr_d;
    end
  end

  // ---------------------------------------------------------------------
  // cv offset and single wrap around the count
  // ---------------------------------------------------------------------
  logic signed [OffW-1:0] off;
  logic signed [ActW-1:0] act_sum, act, cnt_s;
  logic                   use_cv, sel_ok;

  sqcs_offset u_offset (
    .prod_i (prod_q),
    .off_o  (off)
  );

  always_comb begin
    cnt_s   = $signed({2'b00, count_q});
    use_cv  = cfg.cv_en && (count_q > CountW'(1));
    act_sum = $signed({3'b000, step_d}) + ActW'(off);
    act     = $signed({3'b000, step_d});
    if (use_cv) begin
      priority if (act_sum < $signed(ActW'(0))) begin
        act = act_sum + cnt_s;
      end else if (act_sum >= cnt_s) begin
        act = act_sum - cnt_s;
      end else begin
        act = act_sum;
      end
    end
    sel_ok = (count_q != '0) && (act >= $signed(ActW'(0))) && (act < cnt_s);
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic [StepW-1:0] act_ch_q, step_pos_q;
  logic             act_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act_ch_q   <= sel_ok ? act[StepW-1:0] : '0;
      act_vld_q  <= sel_ok;
      step_pos_q <= step_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign active_channel_o = act_ch_q;
  assign active_valid_o   = act_vld_q;
  assign step_position_o  = step_pos_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  a_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(step_q))
    else $error("step changed without an item passing");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("lfsr locked up at zero");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !act_vld_q) |-> (act_ch_q == '0))
    else $error("invalid selection carries a nonzero channel");

endmodule

`default_nettype wire
